@@ hw/rtl/bpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bpt_pkg
// types and constants shared by the particle table core and its submodules
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

    localparam int POS_W   = 31;
    localparam int VEL_W   = 32;
    localparam int DT_W    = 20;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int WORD_W  = 2 * POS_W + 2 * VEL_W;
    localparam int SUM_W   = 38;
    localparam int PROD_W  = VEL_W + DT_W + 1;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORLD_WIDTH  = 1'b0,
        CFG_WORLD_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_ADVANCE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_RM,
        S_MUL,
        S_SUM,
        S_REFL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_x;
        logic [POS_W-1:0]        pos_y;
        logic [POS_W-1:0]        pos_x;
    } t_entry;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic refl_en;
    } t_axis_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/bouncing_particle_table_core.sv @@
// ----------------------------------------------------------------------------
// bouncing_particle_table_core
// particle table with add, remove and advance-with-wall-reflection operations
// ----------------------------------------------------------------------------
// usage
//   s_axis: one command per transaction, tuser selects add, remove or advance
//   m_axis: result transactions, tuser carries the status, tlast marks the
//           final result of a command
//   cfg: writes world width (index 0) and world height (index 1), always ready
// sequencing
//   add, an error, an empty advance and the no-op selector: S_ONE loads the result
//   remove: one ram read of the last entry, moved into the slot by S_RM, then S_ONE
//   advance: each stored entry is read through the single ram port pair, passes
//   the multiply, add and reflect steps and is written back, one entry at a time
//   a new command is taken once the previous command's last result is loaded
// reset clears the entry count and restores the default world size; the
// table memory itself is not cleared. when m_axis stalls, the result waits
// in the output register and the sequencer holds until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bouncing_particle_table_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bpt_pkg::POS_W-1:0]         i_cfg_data,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, slot_index, time_step
    input  wire logic [bpt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func
    input  wire logic [1:0]                        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // entry_index, pos_x_out, pos_y_out, vel_x_out, vel_y_out, entry_count, zero pad
    output logic [bpt_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // status
    output logic [1:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);
    import bpt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_idx, n_idx;
    logic [POS_W-1:0]  r_world_w, r_world_h;
    logic              r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    t_entry            r_res, n_res;
    t_status           r_status, n_status;
    logic [SLOT_W-1:0] r_res_idx, n_res_idx;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [DT_W-1:0]   r_dt, n_dt;

    t_entry            in_entry;
    t_func             in_func;
    logic [SLOT_W-1:0] in_slot;
    logic [DT_W-1:0]   in_dt;
    logic              s_acc;
    logic              out_free;
    logic              adv_last;
    logic [AW-1:0]     last_addr;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    t_entry            rd_entry;
    t_entry            upd_entry;
    t_axis_ctrl        axis_ctrl;

    assign in_entry.pos_x = i_s_axis_tdata[30:0];
    assign in_entry.pos_y = i_s_axis_tdata[61:31];
    assign in_entry.vel_x = i_s_axis_tdata[93:62];
    assign in_entry.vel_y = i_s_axis_tdata[125:94];
    assign in_slot        = i_s_axis_tdata[131:126];
    assign in_dt          = i_s_axis_tdata[151:132];
    assign in_func        = t_func'(i_s_axis_tuser);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign rd_entry        = t_entry'(ram_rdata);
    assign last_addr       = AW'(r_cnt - CW'(1));
    assign adv_last        = (r_idx == last_addr);

    bpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpt_axis u_axis_x (
        .i_clk  (i_clk),
        .i_ctrl (axis_ctrl),
        .i_pos  (rd_entry.pos_x),
        .i_vel  (rd_entry.vel_x),
        .i_dt   (r_dt),
        .i_wall (r_world_w),
        .o_pos  (upd_entry.pos_x),
        .o_vel  (upd_entry.vel_x)
    );

    bpt_axis u_axis_y (
        .i_clk  (i_clk),
        .i_ctrl (axis_ctrl),
        .i_pos  (rd_entry.pos_y),
        .i_vel  (rd_entry.vel_y),
        .i_dt   (r_dt),
        .i_wall (r_world_h),
        .o_pos  (upd_entry.pos_y),
        .o_vel  (upd_entry.vel_y)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_res        = r_res;
        n_status     = r_status;
        n_res_idx    = r_res_idx;
        n_slot       = r_slot;
        n_dt         = r_dt;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = in_entry;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        axis_ctrl    = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_res     = '0;
                    n_status  = ST_OK;
                    n_res_idx = '0;
                    n_slot    = in_slot;
                    n_dt      = in_dt;
                    n_state   = S_ONE;
                    case (in_func)
                        FUNC_ADD: begin
                            if (r_cnt >= CW'(MAX_ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cnt);
                                n_res     = in_entry;
                                n_res_idx = SLOT_W'(r_cnt);
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            n_res_idx = in_slot;
                            if ({1'b0, in_slot} >= CNT_W'(r_cnt)) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = last_addr;
                                n_state   = S_RM;
                            end
                        end
                        FUNC_ADVANCE: begin
                            if (r_cnt != '0) begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_MUL;
                            end
                        end
                        default: begin
                            n_state = S_ONE;
                        end
                    endcase
                end
            end
            S_RM: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_slot);
                ram_wdata = rd_entry;
                n_cnt     = r_cnt - CW'(1);
                n_res     = (AW'(r_slot) == last_addr) ? '0 : rd_entry;
                n_state   = S_ONE;
            end
            S_ONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                    n_out_data   = {{(OUT_DATA_W-139){1'b0}}, CNT_W'(r_cnt), r_res.vel_y,
                                    r_res.vel_x, r_res.pos_y, r_res.pos_x, r_res_idx};
                    n_state      = S_IDLE;
                end
            end
            S_MUL: begin
                axis_ctrl.mul_en = 1'b1;
                n_state          = S_SUM;
            end
            S_SUM: begin
                axis_ctrl.sum_en = 1'b1;
                n_state          = S_REFL;
            end
            S_REFL: begin
                axis_ctrl.refl_en = 1'b1;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_idx;
                    ram_wdata    = upd_entry;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_last   = adv_last;
                    n_out_data   = {{(OUT_DATA_W-139){1'b0}}, CNT_W'(r_cnt),
                                    upd_entry.vel_y, upd_entry.vel_x, upd_entry.pos_y,
                                    upd_entry.pos_x, SLOT_W'(r_idx)};
                    if (adv_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + AW'(1);
                        n_idx     = r_idx + AW'(1);
                        n_state   = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_world_w   <= POS_W'(52428800);
            r_world_h   <= POS_W'(39321600);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WORLD_WIDTH:  r_world_w <= i_cfg_data;
                    CFG_WORLD_HEIGHT: r_world_h <= i_cfg_data;
                    default: begin
                        r_world_w <= r_world_w;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res        <= n_res;
        r_status     <= n_status;
        r_res_idx    <= n_res_idx;
        r_slot       <= n_slot;
        r_dt         <= n_dt;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != n_cnt) |-> ((n_cnt == r_cnt + CW'(1)) || (n_cnt == r_cnt - CW'(1))))
        else $error("entry count moved by more than one");

    a_fin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (CW'(r_idx) < r_cnt))
        else $error("advance index beyond stored entries");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("command accepted while previous one still in work");

endmodule

`default_nettype wire

@@ hw/rtl/bpt_ram.sv @@
// ----------------------------------------------------------------------------
// bpt_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpt_axis.sv @@
// ----------------------------------------------------------------------------
// bpt_axis
// one axis of the advance: multiply, add, wall reflection and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_axis (
    input  wire logic                                i_clk,
    input  wire bpt_pkg::t_axis_ctrl                 i_ctrl,
    input  wire logic [bpt_pkg::POS_W-1:0]           i_pos,
    input  wire logic signed [bpt_pkg::VEL_W-1:0]    i_vel,
    input  wire logic [bpt_pkg::DT_W-1:0]            i_dt,
    input  wire logic [bpt_pkg::POS_W-1:0]           i_wall,
    output logic [bpt_pkg::POS_W-1:0]                o_pos,
    output logic signed [bpt_pkg::VEL_W-1:0]         o_vel
);
    import bpt_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]         r_pos;
    logic signed [VEL_W-1:0]  r_vel;
    logic signed [VEL_W-1:0]  r_vel_neg;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_refl;
    logic signed [VEL_W-1:0]  r_vel_out;
    logic signed [SUM_W-1:0]  wall_ext;
    logic signed [SUM_W-1:0]  wall_dbl;
    logic signed [PROD_W-1:0] delta_full;

    assign wall_ext   = $signed({{(SUM_W-POS_W){1'b0}}, i_wall});
    assign wall_dbl   = $signed({{(SUM_W-POS_W-1){1'b0}}, i_wall, 1'b0});
    assign delta_full = r_prod >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_vel * $signed({1'b0, i_dt});
            r_pos  <= i_pos;
            r_vel  <= i_vel;
        end
        if (i_ctrl.sum_en) begin
            r_sum     <= $signed({{(SUM_W-POS_W){1'b0}}, r_pos}) + SUM_W'(delta_full);
            r_vel_neg <= (r_vel == {1'b1, {(VEL_W-1){1'b0}}}) ? {1'b0, {(VEL_W-1){1'b1}}}
                                                              : -r_vel;
        end
        if (i_ctrl.refl_en) begin
            if (r_sum < 0) begin
                r_refl    <= -r_sum;
                r_vel_out <= r_vel_neg;
            end else if (r_sum > wall_ext) begin
                r_refl    <= wall_dbl - r_sum;
                r_vel_out <= r_vel_neg;
            end else begin
                r_refl    <= r_sum;
                r_vel_out <= r_vel;
            end
        end
    end

    always_comb begin
        if (r_refl < 0) begin
            o_pos = '0;
        end else if (r_refl > wall_ext) begin
            o_pos = i_wall;
        end else begin
            o_pos = r_refl[POS_W-1:0];
        end
    end

    assign o_vel = r_vel_out;

endmodule

`default_nettype wire
